// ===== rtl/core/rlp_pkg.sv =====
// Shared types, codes and the timer helper for the radio link pairing controller.
// No dependencies; imported by rlp_step and radio_link_pairing_fsm_core.
`timescale 1ns / 1ps

package rlp_pkg;

   localparam int IdWidth  = 48;
   localparam int CfgWidth = 16;
   localparam int CsrIndexWidth = 2;

   // event codes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_START   = 3'd1;
   localparam logic [2:0] OP_STOP    = 3'd2;
   localparam logic [2:0] OP_UNPAIR  = 3'd3;
   localparam logic [2:0] OP_PACKET  = 3'd4;
   localparam logic [2:0] OP_RESTORE = 3'd5;

   // received packet kinds
   localparam logic [2:0] PKT_PAIR_REQ   = 3'd0;
   localparam logic [2:0] PKT_VERIFY_RSP = 3'd1;
   localparam logic [2:0] PKT_DISCONNECT = 3'd2;
   localparam logic [2:0] PKT_RESYNC     = 3'd3;

   localparam logic [1:0] TX_NONE       = 2'd0;
   localparam logic [1:0] TX_BEACON     = 2'd1;
   localparam logic [1:0] TX_PAIR_RSP   = 2'd2;
   localparam logic [1:0] TX_VERIFY_REQ = 2'd3;

   localparam logic [1:0] SAVE_NONE      = 2'd0;
   localparam logic [1:0] SAVE_WITH_PEER = 2'd1;
   localparam logic [1:0] SAVE_UNPAIRED  = 2'd2;

   localparam logic [1:0] LINK_NONE = 2'd0;
   localparam logic [1:0] LINK_UP   = 2'd1;
   localparam logic [1:0] LINK_DOWN = 2'd2;

   localparam logic [1:0] MODE_IDLE      = 2'd0;
   localparam logic [1:0] MODE_UNPAIRED  = 2'd1;
   localparam logic [1:0] MODE_VERIFYING = 2'd2;
   localparam logic [1:0] MODE_CONNECTED = 2'd3;

   localparam logic [CsrIndexWidth-1:0] CSR_BEACON_INTERVAL    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BEACON_FIRST_DELAY = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_VERIFY_INTERVAL    = 2'd2;

   localparam logic [CfgWidth-1:0] BEACON_INTERVAL_RST    = 16'd100;
   localparam logic [CfgWidth-1:0] BEACON_FIRST_DELAY_RST = 16'd10;
   localparam logic [CfgWidth-1:0] VERIFY_INTERVAL_RST    = 16'd50;

   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         pkt_kind;
      logic               long_enough;
      logic [IdWidth-1:0] peer_id;
      logic               peer_valid;
   } rlp_req_type;

   typedef struct packed {
      logic [1:0]         tx_kind;
      logic [1:0]         save_kind;
      logic [IdWidth-1:0] save_peer;
      logic [1:0]         link_event;
      logic [1:0]         mode_now;
      logic               is_connected;
   } rlp_rsp_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic                has_peer;
      logic [IdWidth-1:0]  stored_peer;
      logic                beacon_armed;
      logic [CfgWidth-1:0] beacon_count;
      logic                verify_armed;
      logic [CfgWidth-1:0] verify_count;
   } rlp_state_type;

   typedef struct packed {
      logic [CfgWidth-1:0] beacon_interval;
      logic [CfgWidth-1:0] beacon_first_delay;
      logic [CfgWidth-1:0] verify_interval;
   } rlp_cfg_type;

   // One tick of a timer: returns {fire, next count}.
   function automatic logic [CfgWidth:0] timer_tick(input logic armed,
                                                    input logic [CfgWidth-1:0] count);
      logic [CfgWidth-1:0] next_count;
      next_count = count;
      if (armed && (count != '0)) begin
         next_count = count - 1'b1;
      end
      return {armed && (next_count == '0), next_count};
   endfunction

endpackage

// ===== rtl/core/rlp_step.sv =====
// Combinational step of the pairing controller: next state and result word.
// Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_step (
   input  rlp_pkg::rlp_req_type   req,
   input  rlp_pkg::rlp_state_type st,
   input  rlp_pkg::rlp_cfg_type   cfg,
   output rlp_pkg::rlp_state_type st_next,
   output rlp_pkg::rlp_rsp_type   rsp
);
   import rlp_pkg::*;

   logic [CfgWidth:0] beacon_tick;
   logic [CfgWidth:0] verify_tick;

   assign beacon_tick = timer_tick(st.beacon_armed, st.beacon_count);
   assign verify_tick = timer_tick(st.verify_armed, st.verify_count);

   always_comb begin
      st_next = st;
      rsp     = '0;
      case (req.op)
         OP_TICK: begin
            st_next.beacon_count = beacon_tick[CfgWidth-1:0];
            if (beacon_tick[CfgWidth]) begin
               if (st.mode == MODE_UNPAIRED) begin
                  rsp.tx_kind          = TX_BEACON;
                  st_next.beacon_count = cfg.beacon_interval;
               end else begin
                  st_next.beacon_armed = 1'b0;
               end
            end
            st_next.verify_count = verify_tick[CfgWidth-1:0];
            if (verify_tick[CfgWidth]) begin
               if (st.mode == MODE_VERIFYING) begin
                  rsp.tx_kind          = TX_VERIFY_REQ;
                  st_next.verify_count = cfg.verify_interval;
               end else begin
                  st_next.verify_armed = 1'b0;
               end
            end
         end
         OP_START: begin
            if (st.has_peer) begin
               st_next.mode         = MODE_VERIFYING;
               st_next.verify_armed = 1'b1;
               st_next.verify_count = '0;
            end else begin
               st_next.mode         = MODE_UNPAIRED;
               st_next.beacon_armed = 1'b1;
               st_next.beacon_count = cfg.beacon_first_delay;
            end
         end
         OP_STOP: begin
            st_next.mode         = MODE_IDLE;
            st_next.beacon_armed = 1'b0;
            st_next.verify_armed = 1'b0;
            rsp.link_event       = LINK_DOWN;
         end
         OP_UNPAIR: begin
            st_next.has_peer     = 1'b0;
            st_next.stored_peer  = '0;
            st_next.verify_armed = 1'b0;
            rsp.save_kind        = SAVE_UNPAIRED;
            if (st.mode != MODE_IDLE) begin
               st_next.mode         = MODE_UNPAIRED;
               st_next.beacon_armed = 1'b1;
               st_next.beacon_count = cfg.beacon_first_delay;
            end
         end
         OP_PACKET: begin
            case (req.pkt_kind)
               PKT_PAIR_REQ: begin
                  if ((st.mode == MODE_UNPAIRED) && req.long_enough) begin
                     st_next.stored_peer  = req.peer_id;
                     st_next.has_peer     = 1'b1;
                     st_next.beacon_armed = 1'b0;
                     st_next.mode         = MODE_CONNECTED;
                     rsp.tx_kind          = TX_PAIR_RSP;
                     rsp.save_kind        = SAVE_WITH_PEER;
                     rsp.save_peer        = req.peer_id;
                     rsp.link_event       = LINK_UP;
                  end
               end
               PKT_VERIFY_RSP: begin
                  if ((st.mode == MODE_VERIFYING) && req.long_enough &&
                      (req.peer_id == st.stored_peer)) begin
                     st_next.verify_armed = 1'b0;
                     st_next.mode         = MODE_CONNECTED;
                     rsp.link_event       = LINK_UP;
                  end
               end
               PKT_DISCONNECT: begin
                  st_next.mode         = MODE_UNPAIRED;
                  st_next.has_peer     = 1'b0;
                  st_next.stored_peer  = '0;
                  st_next.verify_armed = 1'b0;
                  st_next.beacon_armed = 1'b1;
                  st_next.beacon_count = cfg.beacon_first_delay;
                  rsp.save_kind        = SAVE_UNPAIRED;
                  rsp.link_event       = LINK_DOWN;
               end
               PKT_RESYNC: begin
                  if (st.mode == MODE_CONNECTED) begin
                     st_next.mode         = MODE_VERIFYING;
                     st_next.verify_armed = 1'b1;
                     st_next.verify_count = '0;
                     rsp.link_event       = LINK_DOWN;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_RESTORE: begin
            st_next.has_peer    = req.peer_valid;
            st_next.stored_peer = req.peer_id;
         end
         default: begin
         end
      endcase
      rsp.mode_now     = st_next.mode;
      rsp.is_connected = (st_next.mode == MODE_CONNECTED);
   end

endmodule

// ===== rtl/core/radio_link_pairing_fsm_core.sv =====
// Top level of the radio link pairing controller: input and result registers,
// mode/timer state and configuration registers. Depends on rlp_pkg and rlp_step.
`timescale 1ns / 1ps

// Usage:
// - Event channel (req_*): one word per event: tick, start, stop, unpair,
//   received packet or restore of the stored record. Taken when req_valid
//   and req_ready are both high at a rising clock edge.
// - Result channel (rsp_*): exactly one word per event, in order: packet to
//   send, persist request, link notice and the mode after the event.
// - Configuration (csr_*): csr_write_en writes csr_wdata into the register
//   picked by csr_index (beacon interval, first beacon delay, verify
//   interval); other index values are dropped. Write only while idle.
// - An event that is taken lands in the input register; its result is
//   registered once the result register is free and shows on rsp_* from then on.
// - Throughput: one event per cycle unless rsp_* stalls; the only work per
//   event is one step-logic pass (16-bit timer decrement, 48-bit compare).
// - A stalled receiver holds the result word; the input register still
//   takes one more event, then req_ready drops until the result drains.
// - Reset (synchronous, active high): mode idle, no stored peer, both
//   timers disarmed, registers at 100 / 10 / 50, both channels empty.

module radio_link_pairing_fsm_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_op,
   input  logic [2:0]                          req_pkt_kind,
   input  logic                                req_long_enough,
   input  logic [rlp_pkg::IdWidth-1:0]         req_peer_id,
   input  logic                                req_peer_valid,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_tx_kind,
   output logic [1:0]                          rsp_save_kind,
   output logic [rlp_pkg::IdWidth-1:0]         rsp_save_peer,
   output logic [1:0]                          rsp_link_event,
   output logic [1:0]                          rsp_mode_now,
   output logic                                rsp_is_connected,
   input  logic                                csr_write_en,
   input  logic [rlp_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [rlp_pkg::CfgWidth-1:0]        csr_wdata
);
   import rlp_pkg::*;

   logic          in_valid_ff, in_valid_in;
   rlp_req_type   in_data_ff, in_data_in;
   logic          out_valid_ff, out_valid_in;
   rlp_rsp_type   out_data_ff, out_data_in;
   rlp_state_type state_ff, state_in;
   rlp_cfg_type   cfg_ff, cfg_in;

   rlp_state_type step_state;
   rlp_rsp_type   step_rsp;
   logic          advance;
   logic          take;

   // Move the held event into the result register when that register frees up.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   rlp_step u_step (
      .req     (in_data_ff),
      .st      (state_ff),
      .cfg     (cfg_ff),
      .st_next (step_state),
      .rsp     (step_rsp)
   );

   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      in_data_in   = in_data_ff;
      if (take) begin
         in_data_in.op          = req_op;
         in_data_in.pkt_kind    = req_pkt_kind;
         in_data_in.long_enough = req_long_enough;
         in_data_in.peer_id     = req_peer_id;
         in_data_in.peer_valid  = req_peer_valid;
      end
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
      out_data_in  = advance ? step_rsp : out_data_ff;
      // State commits only when the event's result is registered.
      state_in     = advance ? step_state : state_ff;
      cfg_in       = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BEACON_INTERVAL:    cfg_in.beacon_interval    = csr_wdata;
            CSR_BEACON_FIRST_DELAY: cfg_in.beacon_first_delay = csr_wdata;
            CSR_VERIFY_INTERVAL:    cfg_in.verify_interval    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff               <= 1'b0;
         out_valid_ff              <= 1'b0;
         // All zero: mode idle, no peer, both timers disarmed.
         state_ff                  <= '0;
         cfg_ff.beacon_interval    <= BEACON_INTERVAL_RST;
         cfg_ff.beacon_first_delay <= BEACON_FIRST_DELAY_RST;
         cfg_ff.verify_interval    <= VERIFY_INTERVAL_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers: no reset, qualified by the valid flags.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tx_kind      = out_data_ff.tx_kind;
   assign rsp_save_kind    = out_data_ff.save_kind;
   assign rsp_save_peer    = out_data_ff.save_peer;
   assign rsp_link_event   = out_data_ff.link_event;
   assign rsp_mode_now     = out_data_ff.mode_now;
   assign rsp_is_connected = out_data_ff.is_connected;

endmodule

// ===== tb/sv/rlp_pairing_checker.sv =====
// Checker for the radio link pairing controller: follows the mode and both tick timers,
// predicts one result word per accepted event and compares it field by field.
// Depends on rlp_pkg; instantiated next to the block by radio_link_pairing_fsm_core_test.
`timescale 1ns / 1ps

module rlp_pairing_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [2:0]                        req_op,
   input  logic [2:0]                        req_pkt_kind,
   input  logic                              req_long_enough,
   input  logic [rlp_pkg::IdWidth-1:0]       req_peer_id,
   input  logic                              req_peer_valid,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [1:0]                        rsp_tx_kind,
   input  logic [1:0]                        rsp_save_kind,
   input  logic [rlp_pkg::IdWidth-1:0]       rsp_save_peer,
   input  logic [1:0]                        rsp_link_event,
   input  logic [1:0]                        rsp_mode_now,
   input  logic                              rsp_is_connected,
   input  logic                              csr_write_en,
   input  logic [rlp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rlp_pkg::CfgWidth-1:0]      csr_wdata,
   output int unsigned                       mismatches,
   output int unsigned                       results_owed
);
   import rlp_pkg::*;

   rlp_cfg_type   link_cfg;
   rlp_state_type link_state;
   rlp_rsp_type   results_due[$];
   rlp_req_type   ev;
   rlp_rsp_type   want;
   rlp_rsp_type   got;

   // Apply one event to the pairing state and return the word it produces.
   function automatic rlp_rsp_type next_pairing_result(input rlp_req_type e);
      rlp_rsp_type w;
      logic        beacon_due;
      logic        verify_due;
      w = '0;
      beacon_due = 1'b0;
      verify_due = 1'b0;
      case (e.op)
         OP_TICK: begin
            if (link_state.beacon_armed) begin
               if (link_state.beacon_count != '0)
                  link_state.beacon_count = link_state.beacon_count - 1'b1;
               beacon_due = (link_state.beacon_count == '0);
            end
            if (beacon_due) begin
               if (link_state.mode == MODE_UNPAIRED) begin
                  w.tx_kind = TX_BEACON;
                  link_state.beacon_count = link_cfg.beacon_interval;
               end else begin
                  link_state.beacon_armed = 1'b0;
               end
            end
            if (link_state.verify_armed) begin
               if (link_state.verify_count != '0)
                  link_state.verify_count = link_state.verify_count - 1'b1;
               verify_due = (link_state.verify_count == '0);
            end
            if (verify_due) begin
               if (link_state.mode == MODE_VERIFYING) begin
                  w.tx_kind = TX_VERIFY_REQ;
                  link_state.verify_count = link_cfg.verify_interval;
               end else begin
                  link_state.verify_armed = 1'b0;
               end
            end
         end
         OP_START: begin
            if (link_state.has_peer) begin
               link_state.mode = MODE_VERIFYING;
               link_state.verify_armed = 1'b1;
               link_state.verify_count = '0;
            end else begin
               link_state.mode = MODE_UNPAIRED;
               link_state.beacon_armed = 1'b1;
               link_state.beacon_count = link_cfg.beacon_first_delay;
            end
         end
         OP_STOP: begin
            link_state.mode = MODE_IDLE;
            link_state.beacon_armed = 1'b0;
            link_state.verify_armed = 1'b0;
            w.link_event = LINK_DOWN;
         end
         OP_UNPAIR: begin
            link_state.has_peer = 1'b0;
            link_state.stored_peer = '0;
            link_state.verify_armed = 1'b0;
            w.save_kind = SAVE_UNPAIRED;
            if (link_state.mode != MODE_IDLE) begin
               link_state.mode = MODE_UNPAIRED;
               link_state.beacon_armed = 1'b1;
               link_state.beacon_count = link_cfg.beacon_first_delay;
            end
         end
         OP_PACKET: begin
            case (e.pkt_kind)
               PKT_PAIR_REQ: begin
                  if (link_state.mode == MODE_UNPAIRED && e.long_enough) begin
                     link_state.stored_peer = e.peer_id;
                     link_state.has_peer = 1'b1;
                     link_state.beacon_armed = 1'b0;
                     link_state.mode = MODE_CONNECTED;
                     w.tx_kind = TX_PAIR_RSP;
                     w.save_kind = SAVE_WITH_PEER;
                     w.save_peer = e.peer_id;
                     w.link_event = LINK_UP;
                  end
               end
               PKT_VERIFY_RSP: begin
                  if (link_state.mode == MODE_VERIFYING && e.long_enough &&
                      e.peer_id == link_state.stored_peer) begin
                     link_state.verify_armed = 1'b0;
                     link_state.mode = MODE_CONNECTED;
                     w.link_event = LINK_UP;
                  end
               end
               PKT_DISCONNECT: begin
                  link_state.mode = MODE_UNPAIRED;
                  link_state.has_peer = 1'b0;
                  link_state.stored_peer = '0;
                  link_state.verify_armed = 1'b0;
                  link_state.beacon_armed = 1'b1;
                  link_state.beacon_count = link_cfg.beacon_first_delay;
                  w.save_kind = SAVE_UNPAIRED;
                  w.link_event = LINK_DOWN;
               end
               PKT_RESYNC: begin
                  if (link_state.mode == MODE_CONNECTED) begin
                     link_state.mode = MODE_VERIFYING;
                     link_state.verify_armed = 1'b1;
                     link_state.verify_count = '0;
                     w.link_event = LINK_DOWN;
                  end
               end
               default: ;
            endcase
         end
         OP_RESTORE: begin
            link_state.has_peer = e.peer_valid;
            link_state.stored_peer = e.peer_id;
         end
         default: ;
      endcase
      w.mode_now = link_state.mode;
      w.is_connected = (link_state.mode == MODE_CONNECTED);
      return w;
   endfunction

   task automatic check_field(input string name, input logic [IdWidth-1:0] exp_val,
                              input logic [IdWidth-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         mismatches = mismatches + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         link_cfg.beacon_interval = BEACON_INTERVAL_RST;
         link_cfg.beacon_first_delay = BEACON_FIRST_DELAY_RST;
         link_cfg.verify_interval = VERIFY_INTERVAL_RST;
         link_state = '0;
         link_state.mode = MODE_IDLE;
         results_due.delete();
         mismatches = 0;
         results_owed = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.tx_kind = rsp_tx_kind;
            got.save_kind = rsp_save_kind;
            got.save_peer = rsp_save_peer;
            got.link_event = rsp_link_event;
            got.mode_now = rsp_mode_now;
            got.is_connected = rsp_is_connected;
            if (results_due.size() == 0) begin
               $error("result word with no event waiting for it");
               mismatches = mismatches + 1;
            end else begin
               want = results_due.pop_front();
               check_field("tx_kind", IdWidth'(want.tx_kind), IdWidth'(got.tx_kind));
               check_field("save_kind", IdWidth'(want.save_kind),
                           IdWidth'(got.save_kind));
               check_field("save_peer", want.save_peer, got.save_peer);
               check_field("link_event", IdWidth'(want.link_event),
                           IdWidth'(got.link_event));
               check_field("mode_now", IdWidth'(want.mode_now), IdWidth'(got.mode_now));
               check_field("is_connected", IdWidth'(want.is_connected),
                           IdWidth'(got.is_connected));
            end
         end
         if (req_valid && req_ready) begin
            ev.op = req_op;
            ev.pkt_kind = req_pkt_kind;
            ev.long_enough = req_long_enough;
            ev.peer_id = req_peer_id;
            ev.peer_valid = req_peer_valid;
            results_due.push_back(next_pairing_result(ev));
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_BEACON_INTERVAL:    link_cfg.beacon_interval = csr_wdata;
               CSR_BEACON_FIRST_DELAY: link_cfg.beacon_first_delay = csr_wdata;
               CSR_VERIFY_INTERVAL:    link_cfg.verify_interval = csr_wdata;
               default: ;
            endcase
         end
         results_owed = results_due.size();
      end
   end

endmodule

// ===== tb/sv/radio_link_pairing_fsm_core_test.sv =====
// Top of the pairing controller testbench: clock, reset, event stimulus, result stalls,
// register settings and the verdict. Depends on rlp_pkg, rlp_pairing_checker and the block.
`timescale 1ns / 1ps

module radio_link_pairing_fsm_core_test;
   import rlp_pkg::*;

   // Any accepted word on either channel clears the watchdog, which a correct run
   // never trips, even at 77 percent stalls.
   localparam int StallLimit = 5000;
   // Cycles to let pass once nothing is owed: covers the input and result registers.
   localparam int SettleCycles = 8;
   localparam int Phases = 8;
   localparam int PhaseEvents = 190;

   // Codes the block must treat as no-ops.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [2:0] PKT_OTHER   = 3'd4;
   localparam logic [2:0] PKT_LAST    = 3'd7;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 2'd3;

   localparam logic [IdWidth-1:0] ID_ALL_ONES = '1;
   localparam logic [IdWidth-1:0] ID_PATTERN  = 48'hA5A5_5A5A_0F0F;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_op = OP_TICK;
   logic [2:0]               req_pkt_kind = PKT_PAIR_REQ;
   logic                     req_long_enough = 1'b0;
   logic [IdWidth-1:0]       req_peer_id = '0;
   logic                     req_peer_valid = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_tx_kind;
   logic [1:0]               rsp_save_kind;
   logic [IdWidth-1:0]       rsp_save_peer;
   logic [1:0]               rsp_link_event;
   logic [1:0]               rsp_mode_now;
   logic                     rsp_is_connected;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_BEACON_INTERVAL;
   logic [CfgWidth-1:0]      csr_wdata = '0;

   int unsigned mismatches;
   int unsigned results_owed;
   int unsigned quiet_cycles = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   logic [IdWidth-1:0] id_pool [4];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   radio_link_pairing_fsm_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pkt_kind     (req_pkt_kind),
      .req_long_enough  (req_long_enough),
      .req_peer_id      (req_peer_id),
      .req_peer_valid   (req_peer_valid),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_kind      (rsp_tx_kind),
      .rsp_save_kind    (rsp_save_kind),
      .rsp_save_peer    (rsp_save_peer),
      .rsp_link_event   (rsp_link_event),
      .rsp_mode_now     (rsp_mode_now),
      .rsp_is_connected (rsp_is_connected),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   rlp_pairing_checker pairing_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pkt_kind     (req_pkt_kind),
      .req_long_enough  (req_long_enough),
      .req_peer_id      (req_peer_id),
      .req_peer_valid   (req_peer_valid),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_kind      (rsp_tx_kind),
      .rsp_save_kind    (rsp_save_kind),
      .rsp_save_peer    (rsp_save_peer),
      .rsp_link_event   (rsp_link_event),
      .rsp_mode_now     (rsp_mode_now),
      .rsp_is_connected (rsp_is_connected),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .results_owed     (results_owed)
   );

   // Stall the result channel at random; one assignment per edge keeps ready glitch-free.
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog: end the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit - 1) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [IdWidth-1:0] random_id();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[IdWidth-1:0];
   endfunction

   // Mostly reuse a few identifiers so verify responses match the stored peer often.
   function automatic logic [IdWidth-1:0] pick_id();
      if ($urandom_range(99) < 75) begin
         return id_pool[2'($urandom_range(3))];
      end
      return random_id();
   endfunction

   // Offer one event word and hold it until the block takes it. An idle gap, if any,
   // drops valid first; back-to-back words keep valid high without a dip.
   task automatic send_event(input logic [2:0] op, input logic [2:0] kind,
                             input logic covers_id, input logic [IdWidth-1:0] id,
                             input logic record_valid);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pkt_kind <= kind;
      req_long_enough <= covers_id;
      req_peer_id <= id;
      req_peer_valid <= record_valid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every result word has drained, then let the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      repeat (SettleCycles) @(negedge clock);
      @(posedge clock);
   endtask

   // Write all three timing registers plus a write to the unused index, which must drop.
   task automatic write_timing(input logic [CfgWidth-1:0] beacon_every,
                               input logic [CfgWidth-1:0] beacon_first,
                               input logic [CfgWidth-1:0] verify_every);
      csr_write_en <= 1'b1;
      csr_index <= CSR_BEACON_INTERVAL;
      csr_wdata <= beacon_every;
      @(posedge clock);
      csr_index <= CSR_BEACON_FIRST_DELAY;
      csr_wdata <= beacon_first;
      @(posedge clock);
      csr_index <= CSR_VERIFY_INTERVAL;
      csr_wdata <= verify_every;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= CfgWidth'($urandom_range(16'hFFFF));
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // One random event. Ticks dominate so the timers fire; packets lean toward pair
   // requests and verify responses so the link walks through all four modes.
   task automatic random_event();
      logic [2:0]         op;
      logic [2:0]         kind;
      int                 pick;
      int                 pkt_pick;
      pick = $urandom_range(99);
      pkt_pick = $urandom_range(99);
      kind = 3'($urandom_range(PKT_LAST));
      if (pick < 40) begin
         op = OP_TICK;
      end else if (pick < 48) begin
         op = OP_START;
      end else if (pick < 52) begin
         op = OP_STOP;
      end else if (pick < 56) begin
         op = OP_UNPAIR;
      end else if (pick < 88) begin
         op = OP_PACKET;
         if (pkt_pick < 35) kind = PKT_PAIR_REQ;
         else if (pkt_pick < 70) kind = PKT_VERIFY_RSP;
         else if (pkt_pick < 78) kind = PKT_DISCONNECT;
         else if (pkt_pick < 90) kind = PKT_RESYNC;
         else kind = 3'($urandom_range(PKT_LAST, PKT_OTHER));
      end else if (pick < 96) begin
         op = OP_RESTORE;
      end else begin
         op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      end
      send_event(op, kind, $urandom_range(99) < 85, pick_id(), 1'($urandom_range(1)));
   endtask

   initial begin
      id_pool[0] = '0;
      id_pool[1] = ID_ALL_ONES;
      id_pool[2] = random_id();
      id_pool[3] = random_id();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Short timers so the directed walk sees beacons and verify requests.
      write_timing(16'd2, 16'd1, 16'd1);

      send_event(OP_SPARE_HI, PKT_PAIR_REQ, 1'b0, '0, 1'b0);         // unknown op in idle
      send_event(OP_TICK, PKT_PAIR_REQ, 1'b0, '0, 1'b0);             // nothing armed
      send_event(OP_START, PKT_PAIR_REQ, 1'b0, '0, 1'b0);            // no peer: unpaired
      send_event(OP_TICK, PKT_PAIR_REQ, 1'b0, '0, 1'b0);             // first delay 1: beacon
      send_event(OP_PACKET, PKT_PAIR_REQ, 1'b0, ID_ALL_ONES, 1'b0);  // too short: drop
      send_event(OP_PACKET, PKT_LAST, 1'b1, ID_ALL_ONES, 1'b1);      // unknown packet kind
      send_event(OP_PACKET, PKT_RESYNC, 1'b1, '0, 1'b0);             // resync not connected
      send_event(OP_PACKET, PKT_PAIR_REQ, 1'b1, ID_ALL_ONES, 1'b1);  // pair: connected
      send_event(OP_PACKET, PKT_RESYNC, 1'b1, '0, 1'b0);             // back to verifying
      send_event(OP_PACKET, PKT_VERIFY_RSP, 1'b1, '0, 1'b0);         // wrong peer: drop
      send_event(OP_TICK, PKT_PAIR_REQ, 1'b0, '0, 1'b0);             // zero delay: verify req
      send_event(OP_PACKET, PKT_VERIFY_RSP, 1'b0, ID_ALL_ONES, 1'b0); // too short: drop
      send_event(OP_PACKET, PKT_VERIFY_RSP, 1'b1, ID_ALL_ONES, 1'b0); // match: connected
      send_event(OP_STOP, PKT_PAIR_REQ, 1'b0, '0, 1'b0);             // link down, idle
      send_event(OP_UNPAIR, PKT_PAIR_REQ, 1'b0, '0, 1'b0);           // unpair stays idle
      send_event(OP_RESTORE, PKT_PAIR_REQ, 1'b0, '0, 1'b1);          // stored peer of zero
      send_event(OP_START, PKT_PAIR_REQ, 1'b0, '0, 1'b0);            // peer: verifying
      send_event(OP_UNPAIR, PKT_PAIR_REQ, 1'b0, '0, 1'b0);           // unpaired, beacon armed
      send_event(OP_RESTORE, PKT_PAIR_REQ, 1'b0, ID_PATTERN, 1'b1);
      send_event(OP_START, PKT_PAIR_REQ, 1'b0, '0, 1'b0);            // both timers armed
      send_event(OP_TICK, PKT_PAIR_REQ, 1'b0, '0, 1'b0);             // both fire on one tick
      send_event(OP_PACKET, PKT_DISCONNECT, 1'b0, ID_ALL_ONES, 1'b1);
      send_event(OP_SPARE_LO, PKT_LAST, 1'b1, ID_ALL_ONES, 1'b1);
      send_event(OP_RESTORE, PKT_PAIR_REQ, 1'b0, ID_ALL_ONES, 1'b0);
      send_event(OP_STOP, PKT_PAIR_REQ, 1'b0, '0, 1'b0);

      // Random phases: each one drains, retunes the timers and picks an idling profile.
      for (int phase = 0; phase < Phases; phase++) begin
         drain_results();
         case (phase)
            0: write_timing(16'd1, 16'd0, 16'd1);
            1: write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: write_timing(16'd0, 16'd0, 16'd0);
            5: write_timing(16'd3, 16'd1, 16'd2);
            7: write_timing(BEACON_INTERVAL_RST, BEACON_FIRST_DELAY_RST,
                            VERIFY_INTERVAL_RST);
            default: write_timing(CfgWidth'($urandom_range(6, 1)),
                                  CfgWidth'($urandom_range(6)),
                                  CfgWidth'($urandom_range(6, 1)));
         endcase
         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 77;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 77;
            end
            default: begin
               sender_idle_pct = 32;
               receiver_stall_pct = 32;
            end
         endcase
         id_pool[2] = random_id();
         id_pool[3] = random_id();
         repeat (PhaseEvents) random_event();
      end

      drain_results();
      if (mismatches == 0 && results_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
